// ===== hw/rtl/igmp_host_report_timers_core_macros.svh =====
// ----------------------------------------------------------------------------
// IGMP host report timers - assertion macros
// Clocked assertion wrappers shared by the report timer RTL.
// ----------------------------------------------------------------------------
`ifndef IGMP_HOST_REPORT_TIMERS_CORE_MACROS_SVH
`define IGMP_HOST_REPORT_TIMERS_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define IGMP_HRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define IGMP_HRT_NEVER(lbl, cond, msg) \
  `IGMP_HRT_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/igmp_hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// IGMP host report timers - package
// Item types, message codes and helper functions of the report timer block.
// ----------------------------------------------------------------------------
`default_nettype none

package igmp_hrt_pkg;

  localparam int unsigned SLOT_LIMIT = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned TENTHS_W   = 9;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [1:0] ACT_MSG  = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;

  localparam logic [7:0] TYPE_QUERY     = 8'h11;
  localparam logic [7:0] TYPE_REPORT_V1 = 8'h12;
  localparam logic [7:0] TYPE_REPORT_V2 = 8'h16;

  localparam logic [31:0] ALL_HOSTS_ADDR = 32'hE000_0001;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V1_QUERIER_TICKS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_V1_RESPONSE_SECS = 8'd2;

  localparam logic [COUNT_W-1:0] GROUP_COUNT_RST = 5'd0;
  localparam logic [9:0]         V1_TICKS_RST    = 10'd400;
  localparam logic [4:0]         V1_SECS_RST     = 5'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  msg_type;
    logic [7:0]  max_resp_time;
    logic [31:0] group_addr;
    logic [31:0] dst_addr;
    logic [3:0]  entry_index;
  } igmp_in_t;

  typedef struct packed {
    logic [31:0] report_group;
    logic        report_v1;
    logic        last;
  } igmp_out_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] r;
    r = {1'b0, s[15:1]};
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

  // restoring division by ten, valid below 320
  function automatic logic [4:0] div10(input logic [TENTHS_W-1:0] x);
    logic [12:0] r;
    logic [12:0] dv;
    logic [4:0]  q;
    r = {4'b0, x};
    q = '0;
    for (int k = 4; k >= 0; k--) begin
      dv = 13'd10 << k;
      if (r >= dv) begin
        r    = r - dv;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/igmp_host_report_timers_core.sv =====
// ----------------------------------------------------------------------------
// IGMP host report timers - core
// IGMPv2 host membership report timers for a table of joined groups.
// ----------------------------------------------------------------------------
// A load item or an ignored message is taken in the idle state. A tick, a
// general query, a group query or a report walks the group and timer
// memories slot by slot (read the slot, then modify it and write it back),
// then releases the held final report; the walk holds while the result side
// stalls. Group-specific queries and reports stop at the first matching slot.
// The last report of an item is held back in a pending register so that it
// can carry the last flag.
`default_nettype none
`include "igmp_host_report_timers_core_macros.svh"

module igmp_host_report_timers_core
  import igmp_hrt_pkg::*;
#(
  parameter int unsigned MAX_GROUPS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  igmp_in_t              in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output igmp_out_t             out_item_o
);

  localparam int unsigned DEPTH = (MAX_GROUPS < SLOT_LIMIT) ? MAX_GROUPS : SLOT_LIMIT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RD    = 2'd1;
  localparam logic [1:0] ST_PROC  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_GQUERY = 2'd1;
  localparam logic [1:0] OP_SQUERY = 2'd2;
  localparam logic [1:0] OP_REPORT = 2'd3;

  logic [COUNT_W-1:0]  group_count_q;
  logic [9:0]          v1_ticks_q;
  logic [4:0]          v1_secs_q;

  logic [1:0]          state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [COUNT_W-1:0]  idx_q, idx_d;
  logic [COUNT_W-1:0]  n_q, n_d;
  logic [TENTHS_W-1:0] tenths_q, tenths_d;
  logic [31:0]         key_q, key_d;
  logic                present_q, present_d;
  logic [9:0]          count_q, count_d;
  logic [15:0]         lfsr_q, lfsr_d;
  logic                out_v_q, out_v_d;
  igmp_out_t           out_q, out_d;
  logic                pend_v_q, pend_v_d;
  igmp_out_t           pend_q, pend_d;

  logic [31:0]         grp_mem [DEPTH];
  logic [8:0]          tm_mem [DEPTH];
  logic [DEPTH-1:0]    tm_vld_q;
  logic [31:0]         grp_rd_q;
  logic [8:0]          tm_rd_q;
  logic                rd_vld_q;

  logic                rd_en;
  logic [AW-1:0]       ra;
  logic                grp_we;
  logic                tm_we;
  logic [AW-1:0]       wa;
  logic [8:0]          tm_wdata;

  logic [COUNT_W-1:0]  n_use;
  logic [7:0]          tm_val;
  logic                sent_val;
  logic                match;
  logic [11:0]         t10;
  logic                skip;
  logic [15:0]         lfsr_nx;
  logic [24:0]         prod;
  logic [4:0]          draw;
  logic                emit;
  logic                stall;
  logic                out_free;
  logic                walk;
  logic [TENTHS_W-1:0] v1_tenths;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  assign n_use     = (group_count_q > DEPTH_C) ? DEPTH_C : group_count_q;
  assign v1_tenths = ({4'b0, v1_secs_q} << 3) + ({4'b0, v1_secs_q} << 1);
  assign tm_val    = rd_vld_q ? tm_rd_q[7:0] : 8'd0;
  assign sent_val  = rd_vld_q ? tm_rd_q[8] : 1'b0;
  assign match     = (grp_rd_q == key_q);
  assign t10       = ({4'b0, tm_val} << 3) + ({4'b0, tm_val} << 1);
  assign skip      = (tm_val != 8'd0) && (t10 <= {3'b0, tenths_q});
  assign lfsr_nx   = lfsr_step(lfsr_q);
  assign prod      = {16'b0, tenths_q} * {9'b0, lfsr_nx};
  assign draw      = div10(prod[24:16]);
  assign out_free  = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= GROUP_COUNT_RST;
      v1_ticks_q    <= V1_TICKS_RST;
      v1_secs_q     <= V1_SECS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GROUP_COUNT:      group_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_V1_QUERIER_TICKS: v1_ticks_q    <= cfg_data_i[9:0];
        CFG_V1_RESPONSE_SECS: v1_secs_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    idx_d    = idx_q;
    n_d      = n_q;
    tenths_d = tenths_q;
    key_d    = key_q;
    present_d = present_q;
    count_d  = count_q;
    lfsr_d   = lfsr_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    rd_en    = 1'b0;
    ra       = idx_q[AW-1:0];
    grp_we   = 1'b0;
    tm_we    = 1'b0;
    wa       = idx_q[AW-1:0];
    tm_wdata = '0;
    emit     = 1'b0;
    stall    = 1'b0;
    walk     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d    = in_item_i.group_addr;
          tenths_d = {1'b0, in_item_i.max_resp_time};
          case (in_item_i.action)
            ACT_MSG: begin
              if (in_item_i.msg_type == TYPE_QUERY) begin
                if (in_item_i.group_addr == 32'd0) begin
                  if (in_item_i.dst_addr == ALL_HOSTS_ADDR) begin
                    walk = 1'b1;
                    op_d = OP_GQUERY;
                    if (in_item_i.max_resp_time == 8'd0) begin
                      present_d = 1'b1;
                      count_d   = v1_ticks_q;
                      tenths_d  = v1_tenths;
                    end
                  end
                end else if (in_item_i.dst_addr == in_item_i.group_addr) begin
                  walk = 1'b1;
                  op_d = OP_SQUERY;
                end
              end else if (in_item_i.msg_type == TYPE_REPORT_V1 ||
                           in_item_i.msg_type == TYPE_REPORT_V2) begin
                if (in_item_i.dst_addr == in_item_i.group_addr) begin
                  walk = 1'b1;
                  op_d = OP_REPORT;
                end
              end
            end
            ACT_TICK: begin
              walk = 1'b1;
              op_d = OP_TICK;
              if (count_q != 10'd0) begin
                count_d = count_q - 10'd1;
                if (count_q == 10'd1) begin
                  present_d = 1'b0;
                end
              end
            end
            ACT_LOAD: begin
              if ({1'b0, in_item_i.entry_index} < DEPTH_C) begin
                grp_we   = 1'b1;
                tm_we    = 1'b1;
                wa       = in_item_i.entry_index[AW-1:0];
                tm_wdata = '0;
              end
            end
            default: ;
          endcase
          if (walk && n_use != '0) begin
            n_d     = n_use;
            idx_d   = '0;
            state_d = ST_RD;
          end
        end
      end

      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_PROC;
      end

      ST_PROC: begin
        case (op_q)
          OP_TICK: begin
            if (tm_val != 8'd0) begin
              tm_we    = 1'b1;
              emit     = (tm_val == 8'd1);
              tm_wdata = {emit | sent_val, tm_val - 8'd1};
            end
          end
          OP_GQUERY, OP_SQUERY: begin
            if ((op_q == OP_GQUERY || match) && !skip) begin
              tm_we    = 1'b1;
              emit     = (draw == 5'd0);
              tm_wdata = {emit | sent_val, 3'b0, draw};
              lfsr_d   = lfsr_nx;
            end
          end
          OP_REPORT: begin
            if (match) begin
              tm_we    = 1'b1;
              tm_wdata = '0;
            end
          end
          default: ;
        endcase

        stall = emit && pend_v_q && !out_free;
        if (stall) begin
          tm_we  = 1'b0;
          lfsr_d = lfsr_q;
        end else begin
          if (emit) begin
            if (pend_v_q) begin
              out_v_d      = 1'b1;
              out_d        = pend_q;
              out_d.last   = 1'b0;
            end
            pend_v_d            = 1'b1;
            pend_d.report_group = grp_rd_q;
            pend_d.report_v1    = present_q;
            pend_d.last         = 1'b0;
          end
          if (idx_q == n_q - 5'd1 || (op_q != OP_TICK && op_q != OP_GQUERY && match)) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q + 5'd1;
            state_d = ST_RD;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_TICK;
      idx_q     <= '0;
      n_q       <= '0;
      present_q <= 1'b0;
      count_q   <= '0;
      lfsr_q    <= LFSR_SEED;
      out_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      idx_q     <= idx_d;
      n_q       <= n_d;
      present_q <= present_d;
      count_q   <= count_d;
      lfsr_q    <= lfsr_d;
      out_v_q   <= out_v_d;
      pend_v_q  <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tenths_q <= tenths_d;
    key_q    <= key_d;
    out_q    <= out_d;
    pend_q   <= pend_d;
  end

  always_ff @(posedge clk_i) begin
    if (grp_we) begin
      grp_mem[wa] <= in_item_i.group_addr;
    end
    if (rd_en) begin
      grp_rd_q <= grp_mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tm_we) begin
      tm_mem[wa] <= tm_wdata;
    end
    if (rd_en) begin
      tm_rd_q  <= tm_mem[ra];
      rd_vld_q <= tm_vld_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tm_vld_q <= '0;
    end else if (tm_we) begin
      tm_vld_q[wa] <= 1'b1;
    end
  end

  `IGMP_HRT_ASSERT(a_idle_no_pend, state_q == ST_IDLE |-> !pend_v_q,
                   "held report left over at item end")
  `IGMP_HRT_ASSERT(a_walk_in_range, state_q == ST_PROC |-> idx_q < n_q,
                   "walk index beyond slots in use")
  `IGMP_HRT_NEVER(a_lfsr_zero, lfsr_q == 16'd0, "random generator stuck at zero")
  `IGMP_HRT_NEVER(a_stall_write, stall && (tm_we || lfsr_d != lfsr_q),
                  "state changed while the result side stalls")

endmodule

`default_nettype wire
